[hdl/sss_pkg.sv]
// Shared types and constants for the sensor sample scheduler.
`timescale 1ns / 1ps

package sss_pkg;

   // Field and storage widths.
   localparam int MODE_W  = 3;
   localparam int STAGE_W = 3;
   localparam int TIME_W  = 31;
   localparam int CFG_W   = 17;
   localparam int SOD_W   = 17;
   localparam int LAST_W  = 18;
   localparam int SEND_W  = 31;
   localparam int IDX_W   = 1;

   // Remainder unit sizing: full dividend is a random value, short one a second of day.
   localparam int DIV_W   = TIME_W;
   localparam int DVS_W   = CFG_W;
   localparam int CNT_W   = $clog2(DIV_W);

   localparam logic [DVS_W-1:0]  SECONDS_PER_DAY = DVS_W'(86400);
   localparam logic [CFG_W-1:0]  INTERVAL_RESET  = CFG_W'(300);
   localparam logic [CFG_W-1:0]  PREHEAT_RESET   = CFG_W'(60);
   localparam logic [LAST_W-1:0] LAST_NONE       = '1;
   localparam logic [SEND_W-1:0] SEND_NONE       = '1;

   // Day count by reciprocal multiplication. The reciprocal is rounded up and the shift is
   // the timestamp width plus the bits of the day length, which keeps the quotient exact
   // for every timestamp.
   localparam int DAY_SHIFT = TIME_W + $clog2(SECONDS_PER_DAY);
   localparam int RECIP_W   = TIME_W + 1;
   localparam int QUOT_W    = TIME_W + 1 - $clog2(SECONDS_PER_DAY);
   localparam int PROD_W    = TIME_W + RECIP_W;
   localparam logic [RECIP_W-1:0] DAY_RECIP =
      RECIP_W'(((64'd1 << DAY_SHIFT) + 64'(SECONDS_PER_DAY) - 64'd1) / 64'(SECONDS_PER_DAY));

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] CSR_INTERVAL = IDX_W'(0);
   localparam logic [IDX_W-1:0] CSR_PREHEAT  = IDX_W'(1);

   typedef enum logic [MODE_W-1:0] {
      MODE_QUERY        = 3'd0,
      MODE_START_CALIB  = 3'd1,
      MODE_CALIB_DONE   = 3'd2,
      MODE_START_USER   = 3'd3,
      MODE_SAMPLE_DONE  = 3'd4,
      MODE_SENT         = 3'd5,
      MODE_FIRST_PREHT  = 3'd6,
      MODE_FIRST_SAMPLE = 3'd7
   } mode_type;

   typedef enum logic [STAGE_W-1:0] {
      ST_CONTINUE      = 3'd0,
      ST_PREHEAT       = 3'd1,
      ST_SAMPLING      = 3'd2,
      ST_SEND          = 3'd3,
      ST_PREHEAT_CALIB = 3'd4,
      ST_CALIB         = 3'd5,
      ST_PREHEAT_USER  = 3'd6,
      ST_USER          = 3'd7
   } stage_type;

   typedef struct packed {
      logic              start;
      logic              short_op;
      logic [DIV_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DVS_W-1:0]  remainder;
   } div_rsp_type;

endpackage

[hdl/sss_rem_unit.sv]
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module sss_rem_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  sss_pkg::div_req_type div_req,
   output sss_pkg::div_rsp_type div_rsp
);

   localparam logic [sss_pkg::CNT_W-1:0] LAST_STEP  = sss_pkg::CNT_W'(sss_pkg::DIV_W - 1);
   localparam logic [sss_pkg::CNT_W-1:0] SHORT_SKIP =
      sss_pkg::CNT_W'(sss_pkg::DIV_W - sss_pkg::SOD_W);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [sss_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [sss_pkg::DIV_W-1:0]    shift_ff, shift_in;
   logic [sss_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [sss_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [sss_pkg::DVS_W:0]      trial;
   logic [sss_pkg::DVS_W:0]      diff;

   assign trial = {rem_ff, shift_ff[sss_pkg::DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
         if (div_req.short_op) begin
            // The top bits of a second of day are zero, so skip those steps.
            shift_in = {div_req.dividend[sss_pkg::SOD_W-1:0],
                        {(sss_pkg::DIV_W - sss_pkg::SOD_W){1'b0}}};
            cnt_in   = SHORT_SKIP;
         end else begin
            shift_in = div_req.dividend;
            cnt_in   = '0;
         end
      end else if (busy_ff) begin
         rem_in   = (trial >= {1'b0, dvs_ff}) ? diff[sss_pkg::DVS_W-1:0]
                                              : trial[sss_pkg::DVS_W-1:0];
         shift_in = {shift_ff[sss_pkg::DIV_W-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[hdl/sensor_sample_scheduler.sv]
// Top level of the sensor sample scheduler: request decode, sequencer and schedule state.
`timescale 1ns / 1ps
// Sequencing: a stage query that needs the time of day takes two reciprocal steps for the
//   second of day, 17 remainder steps by the interval and the final decision; a sample-done
//   with a random draw takes a full-width remainder draw; other requests answer from idle.
// Flow control: one request at a time, taken only while the sequencer is idle and the
//   response register is free or being emptied.
// Reset (synchronous, active high) restores the default settings and the idle schedule state.

module sensor_sample_scheduler (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sss_pkg::MODE_W-1:0]   req_mode,
   input  logic [sss_pkg::TIME_W-1:0]   req_current_time,
   input  logic [sss_pkg::TIME_W-1:0]   req_random_value,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sss_pkg::STAGE_W-1:0]  rsp_stage,
   output logic                         rsp_first_flag,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sss_pkg::IDX_W-1:0]    csr_index,
   input  logic [sss_pkg::CFG_W-1:0]    csr_wdata
);

   // Sequencer states. A query passes through the two day steps, the interval step and the
   // final decision; a sample-done with a random draw passes through its own pair.
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_DAY  = 7'b0000010,
      S_SOD  = 7'b0000100,
      S_IVL  = 7'b0001000,
      S_QFIN = 7'b0010000,
      S_RND  = 7'b0100000,
      S_SFIN = 7'b1000000
   } seq_state_type;

   seq_state_type                  state_ff, state_in;

   // Configuration registers.
   logic [sss_pkg::CFG_W-1:0]      interval_ff, interval_in;
   logic [sss_pkg::CFG_W-1:0]      preheat_ff, preheat_in;

   // Schedule state.
   logic [sss_pkg::STAGE_W-1:0]    stage_ff, stage_in;
   logic [sss_pkg::LAST_W-1:0]     last_ff, last_in;
   logic [sss_pkg::SEND_W-1:0]     send_due_ff, send_due_in;
   logic [sss_pkg::TIME_W-1:0]     calib_start_ff, calib_start_in;
   logic [sss_pkg::TIME_W-1:0]     user_start_ff, user_start_in;
   logic                           first_pre_ff, first_pre_in;
   logic                           first_smp_ff, first_smp_in;

   // Working values and the response register.
   logic [sss_pkg::TIME_W-1:0]     stamp_ff, stamp_in;
   logic [sss_pkg::QUOT_W-1:0]     day_quot_ff, day_quot_in;
   logic [sss_pkg::SOD_W-1:0]      sod_ff, sod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sss_pkg::STAGE_W-1:0]    rsp_stage_ff, rsp_stage_in;
   logic                           rsp_flag_ff, rsp_flag_in;

   sss_pkg::div_req_type           div_req;
   sss_pkg::div_rsp_type           div_rsp;

   logic                           out_free;
   logic                           req_fire;
   logic                           rsp_load;
   logic [sss_pkg::PROD_W-1:0]     day_product;
   logic [sss_pkg::TIME_W-1:0]     day_rest;
   logic [sss_pkg::CFG_W-1:0]      eff_interval;
   logic [sss_pkg::CFG_W-1:0]      rnd_range;
   logic [sss_pkg::TIME_W:0]       time_wide;
   logic [sss_pkg::TIME_W:0]       user_due;
   logic [sss_pkg::TIME_W:0]       calib_due;
   logic [sss_pkg::CFG_W-1:0]      to_boundary;
   logic                           sample_due;
   logic                           preheat_due;
   logic                           send_due;

   sss_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // The response register is free when empty or being emptied in this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // An interval of zero behaves as one, so that every second is a boundary.
   assign eff_interval = (interval_ff == '0) ? sss_pkg::CFG_W'(1) : interval_ff;
   // The send offset is drawn over the interval less the pre-heat, or less one second
   // when the pre-heat covers the whole interval.
   assign rnd_range    = (eff_interval > preheat_ff) ? eff_interval - preheat_ff
                                                     : eff_interval - 1'b1;

   // Second of day in two steps: the day count comes from the timestamp times the rounded-up
   // reciprocal of the day length, and the timestamp less that many days is the second of day.
   assign day_product = sss_pkg::PROD_W'(stamp_ff) * sss_pkg::PROD_W'(sss_pkg::DAY_RECIP);
   assign day_rest    = stamp_ff - sss_pkg::TIME_W'(day_quot_ff) *
                                   sss_pkg::TIME_W'(sss_pkg::SECONDS_PER_DAY);

   // Start time plus pre-heat is formed one bit wider so that it never wraps.
   assign time_wide = {1'b0, req_current_time};
   assign user_due  = {1'b0, user_start_ff}  + {{(sss_pkg::TIME_W + 1 - sss_pkg::CFG_W){1'b0}},
                                               preheat_ff};
   assign calib_due = {1'b0, calib_start_ff} + {{(sss_pkg::TIME_W + 1 - sss_pkg::CFG_W){1'b0}},
                                               preheat_ff};

   // Query decision, using the second of day and its remainder by the interval.
   assign to_boundary = (div_rsp.remainder == '0) ? '0 : eff_interval - div_rsp.remainder;
   assign sample_due  = (div_rsp.remainder == '0) &&
                        ({{(sss_pkg::LAST_W - sss_pkg::SOD_W){1'b0}}, sod_ff} != last_ff);
   assign preheat_due = (to_boundary != '0) && (to_boundary <= preheat_ff);
   assign send_due    = {{(sss_pkg::SEND_W - sss_pkg::SOD_W){1'b0}}, sod_ff} >= send_due_ff;

   always_comb begin
      state_in       = state_ff;
      interval_in    = interval_ff;
      preheat_in     = preheat_ff;
      stage_in       = stage_ff;
      last_in        = last_ff;
      send_due_in    = send_due_ff;
      calib_start_in = calib_start_ff;
      user_start_in  = user_start_ff;
      first_pre_in   = first_pre_ff;
      first_smp_in   = first_smp_ff;
      stamp_in       = stamp_ff;
      day_quot_in    = day_quot_ff;
      sod_in         = sod_ff;
      rsp_load       = 1'b0;
      rsp_stage_in   = rsp_stage_ff;
      rsp_flag_in    = 1'b0;

      div_req.start    = 1'b0;
      div_req.short_op = 1'b0;
      div_req.dividend = req_random_value;
      div_req.divisor  = rnd_range;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sss_pkg::CSR_INTERVAL: interval_in = csr_wdata;
            sss_pkg::CSR_PREHEAT:  preheat_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_mode)
                  sss_pkg::MODE_QUERY: begin
                     // Calibration and user runs only wait out their pre-heat; any
                     // other stage needs the time of day first.
                     if (stage_ff == sss_pkg::ST_PREHEAT_USER) begin
                        if (time_wide >= user_due) begin
                           stage_in = sss_pkg::ST_USER;
                        end
                        rsp_stage_in = (time_wide >= user_due) ? sss_pkg::ST_USER : stage_ff;
                        rsp_load     = 1'b1;
                     end else if (stage_ff == sss_pkg::ST_PREHEAT_CALIB) begin
                        if (time_wide >= calib_due) begin
                           stage_in = sss_pkg::ST_CALIB;
                        end
                        rsp_stage_in = (time_wide >= calib_due) ? sss_pkg::ST_CALIB
                                                                : stage_ff;
                        rsp_load     = 1'b1;
                     end else if (stage_ff == sss_pkg::ST_USER ||
                                  stage_ff == sss_pkg::ST_CALIB) begin
                        rsp_stage_in = stage_ff;
                        rsp_load     = 1'b1;
                     end else begin
                        stamp_in = req_current_time;
                        state_in = S_DAY;
                     end
                  end
                  sss_pkg::MODE_START_CALIB: begin
                     calib_start_in = req_current_time;
                     first_pre_in   = 1'b1;
                     first_smp_in   = 1'b1;
                     stage_in       = sss_pkg::ST_PREHEAT_CALIB;
                     rsp_stage_in   = sss_pkg::ST_PREHEAT_CALIB;
                     rsp_load       = 1'b1;
                  end
                  sss_pkg::MODE_START_USER: begin
                     user_start_in = req_current_time;
                     first_pre_in  = 1'b1;
                     first_smp_in  = 1'b1;
                     stage_in      = sss_pkg::ST_PREHEAT_USER;
                     rsp_stage_in  = sss_pkg::ST_PREHEAT_USER;
                     rsp_load      = 1'b1;
                  end
                  sss_pkg::MODE_CALIB_DONE: begin
                     stage_in     = sss_pkg::ST_CONTINUE;
                     rsp_stage_in = sss_pkg::ST_CONTINUE;
                     rsp_load     = 1'b1;
                  end
                  sss_pkg::MODE_SAMPLE_DONE: begin
                     first_pre_in = 1'b1;
                     first_smp_in = 1'b1;
                     if (stage_ff == sss_pkg::ST_SAMPLING && rnd_range != '0) begin
                        // Draw the send offset; stage and send second settle at the end.
                        div_req.start    = 1'b1;
                        div_req.dividend = req_random_value;
                        div_req.divisor  = rnd_range;
                        state_in         = S_RND;
                     end else begin
                        if (stage_ff == sss_pkg::ST_SAMPLING) begin
                           send_due_in = {{(sss_pkg::SEND_W - sss_pkg::LAST_W){1'b0}}, last_ff};
                        end
                        stage_in     = sss_pkg::ST_CONTINUE;
                        rsp_stage_in = sss_pkg::ST_CONTINUE;
                        rsp_load     = 1'b1;
                     end
                  end
                  sss_pkg::MODE_SENT: begin
                     send_due_in  = sss_pkg::SEND_NONE;
                     stage_in     = sss_pkg::ST_CONTINUE;
                     rsp_stage_in = sss_pkg::ST_CONTINUE;
                     rsp_load     = 1'b1;
                  end
                  sss_pkg::MODE_FIRST_PREHT: begin
                     rsp_flag_in  = first_pre_ff;
                     first_pre_in = 1'b0;
                     rsp_stage_in = stage_ff;
                     rsp_load     = 1'b1;
                  end
                  sss_pkg::MODE_FIRST_SAMPLE: begin
                     rsp_flag_in  = first_smp_ff;
                     first_smp_in = 1'b0;
                     rsp_stage_in = stage_ff;
                     rsp_load     = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_DAY: begin
            day_quot_in = day_product[sss_pkg::DAY_SHIFT +: sss_pkg::QUOT_W];
            state_in    = S_SOD;
         end
         S_SOD: begin
            // Second of day is ready: reduce it by the interval on the short path.
            sod_in           = day_rest[sss_pkg::SOD_W-1:0];
            div_req.start    = 1'b1;
            div_req.short_op = 1'b1;
            div_req.dividend = {{(sss_pkg::DIV_W - sss_pkg::SOD_W){1'b0}},
                                day_rest[sss_pkg::SOD_W-1:0]};
            div_req.divisor  = eff_interval;
            state_in         = S_IVL;
         end
         S_IVL: begin
            if (div_rsp.done) begin
               state_in = S_QFIN;
            end
         end
         S_QFIN: begin
            if (out_free) begin
               // The boundary is recorded even while sampling is already in progress.
               if (sample_due) begin
                  last_in = {{(sss_pkg::LAST_W - sss_pkg::SOD_W){1'b0}}, sod_ff};
               end
               if (sample_due || stage_ff == sss_pkg::ST_SAMPLING) begin
                  stage_in     = sss_pkg::ST_SAMPLING;
                  rsp_stage_in = sss_pkg::ST_SAMPLING;
               end else if (preheat_due) begin
                  stage_in     = sss_pkg::ST_PREHEAT;
                  rsp_stage_in = sss_pkg::ST_PREHEAT;
               end else if (send_due) begin
                  stage_in     = sss_pkg::ST_SEND;
                  rsp_stage_in = sss_pkg::ST_SEND;
               end else begin
                  // Nothing due: answer continue and leave the held stage alone.
                  rsp_stage_in = sss_pkg::ST_CONTINUE;
               end
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RND: begin
            if (div_rsp.done) begin
               state_in = S_SFIN;
            end
         end
         S_SFIN: begin
            if (out_free) begin
               send_due_in  = sss_pkg::SEND_W'({1'b0, last_ff} +
                                                {{(sss_pkg::LAST_W + 1 - sss_pkg::DVS_W){1'b0}},
                                                 div_rsp.remainder});
               stage_in     = sss_pkg::ST_CONTINUE;
               rsp_stage_in = sss_pkg::ST_CONTINUE;
               rsp_load     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         interval_ff    <= sss_pkg::INTERVAL_RESET;
         preheat_ff     <= sss_pkg::PREHEAT_RESET;
         stage_ff       <= sss_pkg::ST_CONTINUE;
         last_ff        <= sss_pkg::LAST_NONE;
         send_due_ff    <= sss_pkg::SEND_NONE;
         calib_start_ff <= '0;
         user_start_ff  <= '0;
         first_pre_ff   <= 1'b1;
         first_smp_ff   <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         interval_ff    <= interval_in;
         preheat_ff     <= preheat_in;
         stage_ff       <= stage_in;
         last_ff        <= last_in;
         send_due_ff    <= send_due_in;
         calib_start_ff <= calib_start_in;
         user_start_ff  <= user_start_in;
         first_pre_ff   <= first_pre_in;
         first_smp_ff   <= first_smp_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff    <= stamp_in;
      day_quot_ff <= day_quot_in;
      sod_ff      <= sod_in;
      if (rsp_load) begin
         rsp_stage_ff <= rsp_stage_in;
         rsp_flag_ff  <= rsp_flag_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_stage      = rsp_stage_ff;
   assign rsp_first_flag = rsp_flag_ff;

endmodule

[hdl/sss_checker.sv]
// Port-level checks for the sensor sample scheduler and their binding.
`timescale 1ns / 1ps

module sss_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [sss_pkg::MODE_W-1:0]   req_mode,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [sss_pkg::STAGE_W-1:0]  rsp_stage,
   input  logic                         rsp_first_flag
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stage) && $stable(rsp_first_flag))
      else $error("stalled response changed");

   // Requests that need no arithmetic answer in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_mode != sss_pkg::MODE_QUERY && req_mode != sss_pkg::MODE_SAMPLE_DONE
      |=> rsp_valid)
      else $error("immediate request gave no response");

   // Starting a calibration always answers calibration pre-heat.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_mode == sss_pkg::MODE_START_CALIB
      |=> rsp_stage == sss_pkg::ST_PREHEAT_CALIB && !rsp_first_flag)
      else $error("calibration start answered wrong stage");

   // Calibration done and reading sent always return to continue.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_mode == sss_pkg::MODE_CALIB_DONE || req_mode == sss_pkg::MODE_SENT)
      |=> rsp_stage == sss_pkg::ST_CONTINUE && !rsp_first_flag)
      else $error("done or sent did not answer continue");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sensor_sample_scheduler sss_checker u_sss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_mode       (req_mode),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_stage      (rsp_stage),
   .rsp_first_flag (rsp_first_flag)
);

[tb/sss_schedule_checker.sv]
// Checker for the sensor sample scheduler: schedule prediction and response comparison.
`timescale 1ns / 1ps

module sss_schedule_checker (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [sss_pkg::MODE_W-1:0]   req_mode,
   input  logic [sss_pkg::TIME_W-1:0]   req_current_time,
   input  logic [sss_pkg::TIME_W-1:0]   req_random_value,

   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [sss_pkg::STAGE_W-1:0]  rsp_stage,
   input  logic                         rsp_first_flag,

   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [sss_pkg::IDX_W-1:0]    csr_index,
   input  logic [sss_pkg::CFG_W-1:0]    csr_wdata,

   output int unsigned                  mismatches,
   output int unsigned                  outstanding,
   output int unsigned                  checked,
   output logic [7:0]                   stages_seen
);
   import sss_pkg::*;

   typedef struct packed {
      stage_type stage;
      logic      first_flag;
   } sched_result_type;

   sched_result_type     expected_q[$];

   logic [CFG_W-1:0]     interval_cfg;
   logic [CFG_W-1:0]     preheat_cfg;
   stage_type            sched_stage;
   logic [LAST_W-1:0]    last_sample;
   logic [31:0]          send_due;
   logic [TIME_W-1:0]    calib_start;
   logic [TIME_W-1:0]    user_start;
   logic                 preheat_first;
   logic                 sample_first;

   int unsigned          error_total;
   int unsigned          compare_total;
   logic [7:0]           seen_mask;

   // Advances the predicted schedule by one request and returns the response it should give.
   function automatic sched_result_type schedule_step(input mode_type mode,
                                                      input logic [TIME_W-1:0] now,
                                                      input logic [TIME_W-1:0] rnd);
      sched_result_type res;
      int unsigned      iv;
      int unsigned      sod;
      int unsigned      rem;
      int unsigned      span;
      int unsigned      offset;
      logic             due;
      res.first_flag = 1'b0;
      iv  = (interval_cfg == '0) ? 1 : interval_cfg;
      sod = 32'(now) % 32'(SECONDS_PER_DAY);
      rem = (sod % iv == 0) ? 0 : iv - sod % iv;
      case (mode)
         MODE_QUERY: begin
            if (sched_stage == ST_PREHEAT_USER) begin
               if (33'(now) >= 33'(user_start) + 33'(preheat_cfg))
                  sched_stage = ST_USER;
               res.stage = sched_stage;
            end else if (sched_stage == ST_PREHEAT_CALIB) begin
               if (33'(now) >= 33'(calib_start) + 33'(preheat_cfg))
                  sched_stage = ST_CALIB;
               res.stage = sched_stage;
            end else if (sched_stage == ST_USER || sched_stage == ST_CALIB) begin
               res.stage = sched_stage;
            end else begin
               due = (rem == 0) && (sod != last_sample);
               if (due)
                  last_sample = LAST_W'(sod);
               if (due || sched_stage == ST_SAMPLING) begin
                  sched_stage = ST_SAMPLING;
                  res.stage   = sched_stage;
               end else if (rem > 0 && rem <= preheat_cfg) begin
                  sched_stage = ST_PREHEAT;
                  res.stage   = sched_stage;
               end else if (sod >= send_due) begin
                  sched_stage = ST_SEND;
                  res.stage   = sched_stage;
               end else begin
                  // Nothing due: the answer is continue but the held stage stays put.
                  res.stage = ST_CONTINUE;
               end
            end
         end
         MODE_START_CALIB: begin
            calib_start   = now;
            preheat_first = 1'b1;
            sample_first  = 1'b1;
            sched_stage   = ST_PREHEAT_CALIB;
            res.stage     = sched_stage;
         end
         MODE_CALIB_DONE: begin
            sched_stage = ST_CONTINUE;
            res.stage   = sched_stage;
         end
         MODE_START_USER: begin
            user_start    = now;
            preheat_first = 1'b1;
            sample_first  = 1'b1;
            sched_stage   = ST_PREHEAT_USER;
            res.stage     = sched_stage;
         end
         MODE_SAMPLE_DONE: begin
            if (sched_stage == ST_SAMPLING) begin
               span   = (iv > preheat_cfg) ? iv - preheat_cfg : iv - 1;
               offset = (span == 0) ? 0 : 32'(rnd) % span;
               send_due = 32'(last_sample) + offset;
            end
            preheat_first = 1'b1;
            sample_first  = 1'b1;
            sched_stage   = ST_CONTINUE;
            res.stage     = sched_stage;
         end
         MODE_SENT: begin
            send_due    = 32'(SEND_NONE);
            sched_stage = ST_CONTINUE;
            res.stage   = sched_stage;
         end
         MODE_FIRST_PREHT: begin
            res.first_flag = preheat_first;
            preheat_first  = 1'b0;
            res.stage      = sched_stage;
         end
         default: begin
            res.first_flag = sample_first;
            sample_first   = 1'b0;
            res.stage      = sched_stage;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         interval_cfg  = INTERVAL_RESET;
         preheat_cfg   = PREHEAT_RESET;
         sched_stage   = ST_CONTINUE;
         last_sample   = LAST_NONE;
         send_due      = 32'(SEND_NONE);
         calib_start   = '0;
         user_start    = '0;
         preheat_first = 1'b1;
         sample_first  = 1'b1;
         error_total   = 0;
         compare_total = 0;
         seen_mask     = '0;
         expected_q.delete();
      end else begin
         // Responses are checked before new requests are predicted, so a response can
         // never be matched against a request accepted on the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               error_total++;
               $display("%0t: response with no request waiting: expected none, %s %0d flag %0b",
                        $time, "got stage", rsp_stage, rsp_first_flag);
            end else begin
               want = expected_q.pop_front();
               compare_total++;
               seen_mask[rsp_stage] = 1'b1;
               if (rsp_stage !== want.stage) begin
                  error_total++;
                  $display("%0t: stage mismatch: expected %0d (%s), got %0d",
                           $time, want.stage, want.stage.name(), rsp_stage);
               end
               if (rsp_first_flag !== want.first_flag) begin
                  error_total++;
                  $display("%0t: first_flag mismatch: expected %0b, got %0b",
                           $time, want.first_flag, rsp_first_flag);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_INTERVAL)
               interval_cfg = csr_wdata;
            else if (csr_index == CSR_PREHEAT)
               preheat_cfg = csr_wdata;
         end
         if (req_valid && req_ready)
            expected_q.push_back(schedule_step(mode_type'(req_mode), req_current_time,
                                               req_random_value));
      end
      mismatches  <= error_total;
      outstanding <= expected_q.size();
      checked     <= compare_total;
      stages_seen <= seen_mask;
   end

endmodule

[tb/tb_sensor_sample_scheduler.sv]
// Testbench top for the sensor sample scheduler: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_sensor_sample_scheduler;
   import sss_pkg::*;

   localparam int unsigned       DAY_SECONDS      = 86400;
   // Last whole day whose seconds all stay inside a 31-bit timestamp.
   localparam int unsigned       LAST_DAY         = 24854;
   localparam logic [TIME_W-1:0] LATEST_STAMP     = '1;
   localparam int unsigned       PHASE_COUNT      = 10;
   localparam int unsigned       FIXED_PHASES     = 8;
   localparam int unsigned       PHASE_REQUESTS   = 60;
   localparam int unsigned       LONG_HOLD_CYCLES = 300;
   localparam int unsigned       DRAIN_CYCLES     = 60;

   // Fixed interval and pre-heat settings: the smallest interval, a zero interval (taken as
   // one second), an interval no longer than the pre-heat, the largest values that fit a day
   // and values longer than a day. The last phases draw ordinary settings at random.
   localparam int unsigned FIXED_INTERVAL[FIXED_PHASES] =
      '{2, 2, 10, 0, 1, 86400, 131071, 7};
   localparam int unsigned FIXED_PREHEAT[FIXED_PHASES] =
      '{0, 1, 3, 0, 5, 86399, 131071, 10};

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;

   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [MODE_W-1:0]    req_mode         = '0;
   logic [TIME_W-1:0]    req_current_time = '0;
   logic [TIME_W-1:0]    req_random_value = '0;

   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [STAGE_W-1:0]   rsp_stage;
   logic                 rsp_first_flag;

   logic                 csr_valid        = 1'b0;
   logic                 csr_ready;
   logic [IDX_W-1:0]     csr_index        = '0;
   logic [CFG_W-1:0]     csr_wdata        = '0;

   int unsigned          mismatches;
   int unsigned          outstanding;
   int unsigned          checked;
   logic [7:0]           stages_seen;

   // Shared between the request and response processes; both are written only by the
   // request process, with nonblocking assignments at a clock edge.
   logic                 idling           = 1'b1;
   logic                 long_hold_armed  = 1'b0;

   // The stimulus keeps its own note of the settings it has written, only to aim the
   // request times at interval boundaries and pre-heat windows.
   int unsigned          interval_now     = 300;
   int unsigned          preheat_now      = 60;
   int unsigned          last_boundary    = 0;
   int unsigned          requests_sent    = 0;
   int unsigned          settings_used    = 1;

   always #5 clock = ~clock;

   sensor_sample_scheduler i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_current_time (req_current_time),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_stage        (rsp_stage),
      .rsp_first_flag   (rsp_first_flag),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   sss_schedule_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_current_time (req_current_time),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_stage        (rsp_stage),
      .rsp_first_flag   (rsp_first_flag),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .checked          (checked),
      .stages_seen      (stages_seen)
   );

   // A 31-bit word, now and then pinned to one of its extremes.
   function automatic logic [TIME_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return LATEST_STAMP;
         default: return TIME_W'($urandom);
      endcase
   endfunction

   // A timestamp on a random day whose second of day is the one given.
   function automatic logic [TIME_W-1:0] stamp_at(input int unsigned sod);
      longint unsigned day;
      day = $urandom_range(0, LAST_DAY);
      return TIME_W'(day * DAY_SECONDS + sod % DAY_SECONDS);
   endfunction

   // A timestamp some seconds later, held at the largest timestamp rather than wrapping.
   function automatic logic [TIME_W-1:0] stamp_after(input logic [TIME_W-1:0] base,
                                                     input int unsigned delta);
      longint unsigned sum;
      sum = 64'(base) + delta;
      return (sum > LATEST_STAMP) ? LATEST_STAMP : TIME_W'(sum);
   endfunction

   // A second of day that lies on a boundary of the current interval.
   function automatic int unsigned pick_boundary();
      int unsigned iv;
      iv = (interval_now == 0) ? 1 : interval_now;
      if (iv >= DAY_SECONDS)
         return 0;
      return iv * $urandom_range(0, (DAY_SECONDS - 1) / iv);
   endfunction

   // Offers one request and returns at the edge where it is accepted. Valid is left high,
   // so back-to-back requests never lower and raise it within one time step; any gap in
   // front of the request lowers it first.
   task automatic issue_request(input mode_type mode, input logic [TIME_W-1:0] stamp,
                                input logic [TIME_W-1:0] rnd);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_current_time <= stamp;
      req_random_value <= rnd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   // Configuration is written only once every outstanding request has been answered. The
   // first edge is waited out so that a request accepted just now is already counted.
   task automatic write_register(input logic [IDX_W-1:0] index, input int unsigned value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= CFG_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_INTERVAL)
         interval_now = value;
      else
         preheat_now = value;
   endtask

   // One scheduled reading as the firmware would run it: pre-heat ahead of a boundary,
   // sampling on it, sample done, then one to three queries up to an interval later, and the
   // reading is sent. Steps are dropped at random so that broken sequences occur too.
   task automatic run_reading_cycle();
      int unsigned       iv;
      int unsigned       boundary;
      int unsigned       lead;
      logic [TIME_W-1:0] at;
      iv = (interval_now == 0) ? 1 : interval_now;
      // Reusing the previous boundary on another day hits the already-sampled second.
      boundary = ($urandom_range(0, 3) == 0) ? last_boundary : pick_boundary();
      last_boundary = boundary;
      if (preheat_now > 0 && boundary > 0 && $urandom_range(0, 4) != 0) begin
         lead = $urandom_range(1, (preheat_now < boundary) ? preheat_now : boundary);
         issue_request(MODE_QUERY, stamp_at(boundary - lead), random_word());
         if ($urandom_range(0, 1))
            issue_request(MODE_FIRST_PREHT, random_word(), random_word());
      end
      at = stamp_at(boundary);
      issue_request(MODE_QUERY, at, random_word());
      if ($urandom_range(0, 1))
         issue_request(MODE_QUERY, at, random_word());
      if ($urandom_range(0, 1))
         issue_request(MODE_FIRST_SAMPLE, random_word(), random_word());
      if ($urandom_range(0, 5) != 0)
         issue_request(MODE_SAMPLE_DONE, at, random_word());
      repeat ($urandom_range(1, 3))
         issue_request(MODE_QUERY, stamp_after(at, $urandom_range(0, iv)), random_word());
      if ($urandom_range(0, 3) != 0)
         issue_request(MODE_SENT, random_word(), random_word());
   endtask

   // A calibration or user sampling run: start, queries inside and past the pre-heat
   // delay, then one of the requests that ends it.
   task automatic run_hold_cycle(input mode_type start_mode);
      logic [TIME_W-1:0] start_at;
      start_at = ($urandom_range(0, 3) == 0) ? random_word()
                                             : stamp_at($urandom_range(0, DAY_SECONDS - 1));
      issue_request(start_mode, start_at, random_word());
      if (preheat_now > 0 && $urandom_range(0, 1))
         issue_request(MODE_QUERY, stamp_after(start_at, $urandom_range(0, preheat_now - 1)),
                       random_word());
      if ($urandom_range(0, 1))
         issue_request(MODE_FIRST_PREHT, random_word(), random_word());
      issue_request(MODE_QUERY, stamp_after(start_at, preheat_now + $urandom_range(0, 2)),
                    random_word());
      issue_request(MODE_QUERY, stamp_after(start_at, preheat_now + $urandom_range(0, 5000)),
                    random_word());
      if ($urandom_range(0, 1))
         issue_request(MODE_FIRST_SAMPLE, random_word(), random_word());
      case ($urandom_range(0, 3))
         0:       issue_request(MODE_SAMPLE_DONE, random_word(), random_word());
         1:       issue_request(MODE_SENT, random_word(), random_word());
         default: issue_request(MODE_CALIB_DONE, random_word(), random_word());
      endcase
   endtask

   // Unstructured requests of any mode and any field values.
   task automatic run_noise();
      repeat ($urandom_range(1, 3))
         issue_request(mode_type'($urandom_range(0, 7)), random_word(), random_word());
   endtask

   // Response side. Ready is stalled in random bursts while idling is allowed, and once,
   // when armed, it is held low for a long stretch while requests keep being offered, so
   // that the block fills up and has to stall its request channel.
   initial begin : response_drain
      int unsigned hold;
      logic        long_hold_done;
      long_hold_done = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_armed && !long_hold_done) begin
            rsp_ready <= 1'b0;
            for (hold = 0; hold < LONG_HOLD_CYCLES; hold++) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Request side: reset, a directed pass at the reset settings, then one random phase per
   // interval and pre-heat setting, then draining and the verdict.
   initial begin : stimulus
      int unsigned phase_start;
      int unsigned next_interval;
      int unsigned next_preheat;
      int unsigned groups;
      groups = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed pass with the reset interval of 300 s and pre-heat of 60 s. The one-shot
      // flags read as set after reset and clear once read.
      issue_request(MODE_FIRST_SAMPLE, '0, '0);
      issue_request(MODE_FIRST_SAMPLE, '0, '0);
      issue_request(MODE_FIRST_PREHT, LATEST_STAMP, LATEST_STAMP);
      // Midnight is a boundary and nothing has been sampled; asking again in the same
      // second keeps sampling without taking a new sample.
      issue_request(MODE_QUERY, '0, '0);
      issue_request(MODE_QUERY, '0, '0);
      // Send time drawn from the largest random value.
      issue_request(MODE_SAMPLE_DONE, '0, LATEST_STAMP);
      // One second before a boundary, and the latest timestamp, both fall in pre-heat.
      issue_request(MODE_QUERY, TIME_W'(DAY_SECONDS + 299), '0);
      issue_request(MODE_QUERY, LATEST_STAMP, '0);
      // Past the send time, then a query with nothing due while send is held.
      issue_request(MODE_QUERY, TIME_W'(2 * DAY_SECONDS + 200), '0);
      issue_request(MODE_QUERY, TIME_W'(2 * DAY_SECONDS + 100), '0);
      issue_request(MODE_SENT, '0, '0);
      // A fresh boundary, a small send offset, then sample done outside sampling, which
      // must leave the send time alone.
      issue_request(MODE_QUERY, TIME_W'(3 * DAY_SECONDS + 300), '0);
      issue_request(MODE_SAMPLE_DONE, '0, TIME_W'(5));
      issue_request(MODE_SAMPLE_DONE, '0, LATEST_STAMP);
      issue_request(MODE_QUERY, TIME_W'(3 * DAY_SECONDS + 306), '0);
      issue_request(MODE_SENT, LATEST_STAMP, '0);
      // Calibration from the latest timestamp: start plus pre-heat must not wrap.
      issue_request(MODE_START_CALIB, LATEST_STAMP, '0);
      issue_request(MODE_QUERY, LATEST_STAMP, '0);
      issue_request(MODE_CALIB_DONE, '0, '0);
      // Calibration one second short of and exactly at the end of its pre-heat.
      issue_request(MODE_START_CALIB, TIME_W'(1000), '0);
      issue_request(MODE_QUERY, TIME_W'(1059), '0);
      issue_request(MODE_QUERY, TIME_W'(1060), '0);
      issue_request(MODE_FIRST_PREHT, '0, '0);
      issue_request(MODE_CALIB_DONE, '0, '0);
      // User sampling from time zero, ended by a sample done outside sampling.
      issue_request(MODE_START_USER, '0, '0);
      issue_request(MODE_QUERY, TIME_W'(59), '0);
      issue_request(MODE_QUERY, TIME_W'(60), '0);
      issue_request(MODE_SAMPLE_DONE, '0, LATEST_STAMP);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < FIXED_PHASES) begin
            next_interval = FIXED_INTERVAL[phase];
            next_preheat  = FIXED_PREHEAT[phase];
         end else begin
            next_interval = $urandom_range(2, 400);
            next_preheat  = $urandom_range(0, next_interval);
         end
         if ($urandom_range(0, 1)) begin
            write_register(CSR_INTERVAL, next_interval);
            write_register(CSR_PREHEAT, next_preheat);
         end else begin
            write_register(CSR_PREHEAT, next_preheat);
            write_register(CSR_INTERVAL, next_interval);
         end
         settings_used++;
         if (phase == 2)
            long_hold_armed <= 1'b1;
         // The final phase runs with neither side idling.
         if (phase == PHASE_COUNT - 1)
            idling <= 1'b0;
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            groups++;
            if (phase != PHASE_COUNT - 1 && groups % 6 == 0)
               idling <= ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: run_reading_cycle();
               5, 6:          run_hold_cycle(MODE_START_CALIB);
               7:             run_hold_cycle(MODE_START_USER);
               default:       run_noise();
            endcase
         end
      end

      // Drain: every request must be answered, then a quiet spell catches strays.
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d requests over %0d interval and pre-heat settings, %0d responses checked.",
               requests_sent, settings_used, checked);
      $display("Summary: response stages observed, one bit per stage code: %b.", stages_seen);
      if (mismatches == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // About ten times the slowest expected run: every request at its longest latency plus
   // the longest gaps on both sides, the long hold and the configuration writes.
   initial begin : watchdog
      #5000000;
      $display("Timeout: the scheduler stopped answering requests.");
      $display("Test completed with failures");
      $finish;
   end

endmodule
